### rtl/qrm_pkg.sv
// ----------------------------------------------------------------------------
// qrm_pkg
// widths, entry codes and pipeline bundle types of the quaternion to matrix block
// ----------------------------------------------------------------------------
package qrm_pkg;

	// fraction bits of each matrix entry
	localparam int OUT_FRAC_BITS = 14;

	localparam int IN_W    = 16;
	localparam int OUT_W   = 16;
	localparam int NUM_ENT = 9;
	localparam int PROD_W  = 2 * IN_W;
	// norm up to 4 * 2^30, one bit more than a product
	localparam int DEN_W   = PROD_W + 1;
	// signed numerators, magnitude up to the norm
	localparam int NUM_W   = DEN_W + 1;
	// partial remainder stays below the norm
	localparam int REM_W   = DEN_W - 1;
	// quotient of mag * 2^(F+1) / norm, one guard bit for rounding
	localparam int QUO_W   = OUT_FRAC_BITS + 2;
	localparam int DIV_STEPS = OUT_FRAC_BITS + 1;
	localparam int RES_W   = OUT_FRAC_BITS + 2;
	localparam int WIDE_W  = 32;

	localparam logic [WIDE_W-1:0] ONE_WIDE = WIDE_W'(1) << OUT_FRAC_BITS;

	// matrix entry codes, row major
	localparam int E00 = 0;
	localparam int E01 = 1;
	localparam int E02 = 2;
	localparam int E10 = 3;
	localparam int E11 = 4;
	localparam int E12 = 5;
	localparam int E20 = 6;
	localparam int E21 = 7;
	localparam int E22 = 8;

	typedef logic signed [PROD_W-1:0] qrm_prd_t;
	typedef logic signed [NUM_W-1:0]  qrm_num_t;
	typedef logic [REM_W-1:0]         qrm_rem_t;
	typedef logic [QUO_W-1:0]         qrm_quo_t;

	typedef struct packed {
		qrm_prd_t ww;
		qrm_prd_t xx;
		qrm_prd_t yy;
		qrm_prd_t zz;
		qrm_prd_t xy;
		qrm_prd_t xz;
		qrm_prd_t yz;
		qrm_prd_t wx;
		qrm_prd_t wy;
		qrm_prd_t wz;
	} qrm_prod_t;

	typedef struct packed {
		logic               zero;
		logic [NUM_ENT-1:0] neg;
		logic [DEN_W-1:0]   den;
	} qrm_ctl_t;

	typedef struct packed {
		qrm_ctl_t                 ctl;
		qrm_rem_t [NUM_ENT-1:0]   rem;
		qrm_quo_t [NUM_ENT-1:0]   quo;
	} qrm_div_t;

endpackage

### rtl/qrm_mult.sv
// ----------------------------------------------------------------------------
// qrm_mult
// first stage: the ten component products
// ----------------------------------------------------------------------------
module qrm_mult (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic signed [qrm_pkg::IN_W-1:0] w,
	input  logic signed [qrm_pkg::IN_W-1:0] x,
	input  logic signed [qrm_pkg::IN_W-1:0] y,
	input  logic signed [qrm_pkg::IN_W-1:0] z,
	output logic                            valid_s1,
	output qrm_pkg::qrm_prod_t              prod_s1
);
	import qrm_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1.ww <= w * w;
		prod_s1.xx <= x * x;
		prod_s1.yy <= y * y;
		prod_s1.zz <= z * z;
		prod_s1.xy <= x * y;
		prod_s1.xz <= x * z;
		prod_s1.yz <= y * z;
		prod_s1.wx <= w * x;
		prod_s1.wy <= w * y;
		prod_s1.wz <= w * z;
	end

endmodule

### rtl/qrm_sum.sv
// ----------------------------------------------------------------------------
// qrm_sum
// norm and numerators, then magnitudes and divider set-up
// ----------------------------------------------------------------------------
module qrm_sum (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_s1,
	input  qrm_pkg::qrm_prod_t prod_s1,
	output logic               valid_s3,
	output qrm_pkg::qrm_div_t  div_s3
);
	import qrm_pkg::*;

	logic                     valid_s2;
	logic [DEN_W-1:0]         den_s2;
	qrm_num_t [NUM_ENT-1:0]   num_s2;
	qrm_num_t [NUM_ENT-1:0]   num_nxt;
	logic [DEN_W-1:0]         den_nxt;
	qrm_div_t                 div_nxt;

	function automatic qrm_num_t sx(input qrm_prd_t p);
		return NUM_W'(p);
	endfunction

	function automatic logic [DEN_W-1:0] dx(input qrm_prd_t p);
		return DEN_W'(p);
	endfunction

	always_comb begin
		den_nxt = dx(prod_s1.ww) + dx(prod_s1.xx) + dx(prod_s1.yy) + dx(prod_s1.zz);
		num_nxt[E00] = sx(prod_s1.ww) + sx(prod_s1.xx) - sx(prod_s1.yy) - sx(prod_s1.zz);
		num_nxt[E01] = (sx(prod_s1.xy) + sx(prod_s1.wz)) <<< 1;
		num_nxt[E02] = (sx(prod_s1.xz) - sx(prod_s1.wy)) <<< 1;
		num_nxt[E10] = (sx(prod_s1.xy) - sx(prod_s1.wz)) <<< 1;
		num_nxt[E11] = sx(prod_s1.ww) - sx(prod_s1.xx) + sx(prod_s1.yy) - sx(prod_s1.zz);
		num_nxt[E12] = (sx(prod_s1.yz) + sx(prod_s1.wx)) <<< 1;
		num_nxt[E20] = (sx(prod_s1.xz) + sx(prod_s1.wy)) <<< 1;
		num_nxt[E21] = (sx(prod_s1.yz) - sx(prod_s1.wx)) <<< 1;
		num_nxt[E22] = sx(prod_s1.ww) - sx(prod_s1.xx) - sx(prod_s1.yy) + sx(prod_s1.zz);
	end

	// magnitude equal to the norm gives the top quotient bit at once
	always_comb begin
		qrm_num_t         mag;
		logic             full;
		div_nxt.ctl.zero = (den_s2 == '0);
		div_nxt.ctl.den  = den_s2;
		for (int i = 0; i < NUM_ENT; i++) begin
			div_nxt.ctl.neg[i] = num_s2[i][NUM_W-1];
			mag  = num_s2[i][NUM_W-1] ? -num_s2[i] : num_s2[i];
			full = (mag[DEN_W-1:0] == den_s2);
			div_nxt.rem[i] = full ? '0 : mag[REM_W-1:0];
			div_nxt.quo[i] = QUO_W'(full);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		den_s2 <= den_nxt;
		num_s2 <= num_nxt;
		div_s3 <= div_nxt;
	end

endmodule

### rtl/qrm_div_step.sv
// ----------------------------------------------------------------------------
// qrm_div_step
// one restoring division step, nine lanes sharing one divisor
// ----------------------------------------------------------------------------
module qrm_div_step (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_in,
	input  qrm_pkg::qrm_div_t div_in,
	output logic              valid_out,
	output qrm_pkg::qrm_div_t div_out
);
	import qrm_pkg::*;

	qrm_div_t div_nxt;

	always_comb begin
		logic [DEN_W-1:0] d;
		logic             ge;
		div_nxt.ctl = div_in.ctl;
		for (int i = 0; i < NUM_ENT; i++) begin
			d  = {div_in.rem[i], 1'b0};
			ge = (d >= div_in.ctl.den);
			div_nxt.rem[i] = ge ? REM_W'(d - div_in.ctl.den) : REM_W'(d);
			div_nxt.quo[i] = {div_in.quo[i][QUO_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		div_out <= div_nxt;
	end

endmodule

### rtl/qrm_round.sv
// ----------------------------------------------------------------------------
// qrm_round
// last stage: round half away, clamp, sign, identity on a zero quaternion
// ----------------------------------------------------------------------------
module qrm_round (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       valid_in,
	input  qrm_pkg::qrm_div_t                          div_in,
	output logic                                       done_q,
	output logic [qrm_pkg::NUM_ENT-1:0][qrm_pkg::OUT_W-1:0] ent_q,
	output logic                                       zero_q
);
	import qrm_pkg::*;

	logic [NUM_ENT-1:0][OUT_W-1:0] ent_nxt;

	function automatic logic [OUT_W-1:0] round_ent(input qrm_quo_t q2, input logic neg);
		logic [QUO_W:0]               inc;
		logic [RES_W-1:0]             q;
		logic signed [RES_W-1:0]      val;
		logic signed [WIDE_W-1:0]     wide;
		inc = {1'b0, q2} + 1'b1;
		q   = inc[QUO_W:1];
		if (q > ONE_WIDE[RES_W-1:0]) begin
			q = ONE_WIDE[RES_W-1:0];
		end
		val  = neg ? -signed'(q) : signed'(q);
		wide = WIDE_W'(val);
		return wide[OUT_W-1:0];
	endfunction

	always_comb begin
		for (int i = 0; i < NUM_ENT; i++) begin
			if (div_in.ctl.zero) begin
				ent_nxt[i] = (i == E00 || i == E11 || i == E22) ? ONE_WIDE[OUT_W-1:0] : '0;
			end else begin
				ent_nxt[i] = round_ent(div_in.quo[i], div_in.ctl.neg[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		ent_q  <= ent_nxt;
		zero_q <= div_in.ctl.zero;
	end

endmodule

### rtl/quaternion_to_rotation_matrix.sv
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix
// the done strobe comes once the request has passed the products, sum, divider
//   and round stages after it is taken; one request per cycle sustained
// the divider sets the depth: one quotient bit per stage, OUT_FRAC_BITS + 1 steps
// busy is never raised; the result is shown for one cycle and cannot be stalled
// reset clears only the valid bits of the pipeline, no result is left in flight
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [qrm_pkg::IN_W-1:0]    quat_w,
	input  logic signed [qrm_pkg::IN_W-1:0]    quat_x,
	input  logic signed [qrm_pkg::IN_W-1:0]    quat_y,
	input  logic signed [qrm_pkg::IN_W-1:0]    quat_z,
	output logic                               done,
	output logic signed [qrm_pkg::OUT_W-1:0]   row0_col0,
	output logic signed [qrm_pkg::OUT_W-1:0]   row0_col1,
	output logic signed [qrm_pkg::OUT_W-1:0]   row0_col2,
	output logic signed [qrm_pkg::OUT_W-1:0]   row1_col0,
	output logic signed [qrm_pkg::OUT_W-1:0]   row1_col1,
	output logic signed [qrm_pkg::OUT_W-1:0]   row1_col2,
	output logic signed [qrm_pkg::OUT_W-1:0]   row2_col0,
	output logic signed [qrm_pkg::OUT_W-1:0]   row2_col1,
	output logic signed [qrm_pkg::OUT_W-1:0]   row2_col2,
	output logic                               zero_error
);
	import qrm_pkg::*;

	// request taken into the first stage
	logic                          take;
	// products stage
	logic                          valid_s1;
	qrm_prod_t                     prod_s1;
	// divider chain, entry 0 is the set-up stage, then one per quotient bit
	logic                          vld_p [DIV_STEPS+1];
	qrm_div_t                      div_p [DIV_STEPS+1];
	// registered result
	logic [NUM_ENT-1:0][OUT_W-1:0] ent;

	// every stage moves each cycle, so the front never has to wait
	assign busy = 1'b0;
	assign take = start && !busy;

	// ten products of the components, one multiplier each
	qrm_mult u_mult (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (take),
		.w        (quat_w),
		.x        (quat_x),
		.y        (quat_y),
		.z        (quat_z),
		.valid_s1 (valid_s1),
		.prod_s1  (prod_s1)
	);

	// norm, numerators with sign split off, and the divider start values
	qrm_sum u_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.prod_s1  (prod_s1),
		.valid_s3 (vld_p[0]),
		.div_s3   (div_p[0])
	);

	// the nine ratios share the norm as divisor; each stage yields one bit
	for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
		qrm_div_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.valid_in  (vld_p[g]),
			.div_in    (div_p[g]),
			.valid_out (vld_p[g+1]),
			.div_out   (div_p[g+1])
		);
	end

	// guard bit gives round half away from zero, then clamp and sign
	qrm_round u_round (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_in (vld_p[DIV_STEPS]),
		.div_in   (div_p[DIV_STEPS]),
		.done_q   (done),
		.ent_q    (ent),
		.zero_q   (zero_error)
	);

	assign row0_col0 = ent[E00];
	assign row0_col1 = ent[E01];
	assign row0_col2 = ent[E02];
	assign row1_col0 = ent[E10];
	assign row1_col1 = ent[E11];
	assign row1_col2 = ent[E12];
	assign row2_col0 = ent[E20];
	assign row2_col1 = ent[E21];
	assign row2_col2 = ent[E22];

endmodule
